FILE: rtl/core/spfa_pkg.sv
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared types and sizing constants of the first-fit string pool allocator.
// ----------------------------------------------------------------------------
package spfa_pkg;

	localparam int BLOCK_BYTES      = 1024;
	localparam int BLOCK_COUNT      = 16;
	localparam int MAX_STRING_BYTES = 128;

	localparam int POOL_DEPTH = BLOCK_BYTES * BLOCK_COUNT;
	localparam int POOL_AW    = 14;
	localparam int BLK_W      = 4;
	localparam int OFF_W      = 10;
	localparam int LIM_W      = OFF_W + 1;
	localparam int BCNT_W     = BLK_W + 1;
	localparam int LEN_W      = 8;
	localparam int PEND_AW    = 7;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] KIND_ORD   = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_EMPTY   = 2'd1;
	localparam logic [1:0] STAT_INVALID = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FREE,
		ST_SCAN,
		ST_PLACE,
		ST_STORE,
		ST_RESP
	} state_t;

endpackage

FILE: rtl/core/spfa_ram.sv
// ----------------------------------------------------------------------------
// spfa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/string_pool_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// string_pool_first_fit_allocator
// Byte pool of fixed blocks holding zero-terminated strings, first-fit alloc.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 16384-byte pool to zero, one byte per
// cycle, so s_tready stays low until the sweep is done. A non-zero alloc
// character is only collected in the pending buffer and gets no response.
// A read passes through the READ and RESP states to the output register. A
// free walks the string one byte per cycle, clearing it up to its terminator
// or the block end. The alloc terminator is the expensive transaction: the
// first-fit search walks the blocks in use, the current one only up to its
// append point, through the single pool read port, one byte per cycle
// within a block, until a hole fits; then the string is copied from the
// pending buffer at one byte per cycle, followed by the terminator. Results
// wait in an output register, and the block goes back to accepting
// transactions as soon as a result has moved into that register, even
// while the receiver has not yet taken it.
module string_pool_first_fit_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: char_byte[7:0], key[21:8], char_offset[28:22], zero fill.
	input  logic [31:0] s_tdata,
	// s_tuser: operation[1:0], key_kind[3:2].
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: result_key[13:0], read_byte[21:14], zero fill.
	output logic [23:0] m_tdata,
	// m_tuser: status[1:0].
	output logic [1:0]  m_tuser
);

	localparam logic [spfa_pkg::LIM_W-1:0] LIMIT_FULL = spfa_pkg::LIM_W'(spfa_pkg::BLOCK_BYTES);
	localparam logic [spfa_pkg::LEN_W-1:0] LEN_MAX =
		spfa_pkg::LEN_W'(spfa_pkg::MAX_STRING_BYTES);

	// Input field unpacking.
	logic [1:0]                    in_op;
	logic [7:0]                    in_char;
	logic [1:0]                    in_kind;
	logic [spfa_pkg::POOL_AW-1:0]  in_key;
	logic [6:0]                    in_coff;
	logic [spfa_pkg::BLK_W-1:0]    in_blk;
	logic [spfa_pkg::LIM_W-1:0]    in_rd_off;

	assign in_op     = s_tuser[1:0];
	assign in_kind   = s_tuser[3:2];
	assign in_char   = s_tdata[7:0];
	assign in_key    = s_tdata[21:8];
	assign in_coff   = s_tdata[28:22];
	assign in_blk    = in_key[spfa_pkg::POOL_AW-1:spfa_pkg::OFF_W];
	assign in_rd_off = {1'b0, in_key[spfa_pkg::OFF_W-1:0]} + spfa_pkg::LIM_W'(in_coff);

	spfa_pkg::state_t state_q, state_n;

	// Allocation bookkeeping.
	logic [spfa_pkg::BCNT_W-1:0]  blocks_q;
	logic [spfa_pkg::BLK_W-1:0]   cur_blk_q;
	logic [spfa_pkg::LIM_W-1:0]   cur_off_q;
	logic [spfa_pkg::LEN_W-1:0]   pend_len_q;
	logic [spfa_pkg::LEN_W-1:0]   slen_q;
	logic [spfa_pkg::LEN_W-1:0]   need_q;

	// Clearing sweep.
	logic [spfa_pkg::POOL_AW-1:0] clr_q;

	// Free walk.
	logic [spfa_pkg::BLK_W-1:0]   wblk_q;
	logic [spfa_pkg::LIM_W-1:0]   woff_q;

	// First-fit scan: issue side and evaluate side.
	logic [spfa_pkg::BCNT_W-1:0]  sb_q;
	logic [spfa_pkg::LIM_W-1:0]   si_q;
	logic                         sdone_q;
	logic                         sv_s1;
	logic [spfa_pkg::BLK_W-1:0]   sb_s1;
	logic [spfa_pkg::OFF_W-1:0]   si_s1;
	logic                         skip_q;
	logic [spfa_pkg::LEN_W-1:0]   run_q;
	logic [spfa_pkg::OFF_W-1:0]   start_q;

	// Store copy.
	logic [spfa_pkg::POOL_AW-1:0] pos_q;
	logic [spfa_pkg::LEN_W-1:0]   k_q;
	logic                         pv_s1;
	logic [spfa_pkg::LEN_W-1:0]   k_s1;

	// Result holding and output registers.
	logic [1:0]                   res_stat_q;
	logic [spfa_pkg::POOL_AW-1:0] res_key_q;
	logic [7:0]                   res_byte_q;
	logic                         out_valid_q;
	logic [1:0]                   out_stat_q;
	logic [spfa_pkg::POOL_AW-1:0] out_key_q;
	logic [7:0]                   out_byte_q;

	// Memory ports.
	logic                         pool_we;
	logic [spfa_pkg::POOL_AW-1:0] pool_waddr;
	logic [7:0]                   pool_wdata;
	logic [spfa_pkg::POOL_AW-1:0] pool_raddr;
	logic [7:0]                   pool_rdata;
	logic                         pend_we;
	logic [spfa_pkg::PEND_AW-1:0] pend_waddr;
	logic [spfa_pkg::PEND_AW-1:0] pend_raddr;
	logic [7:0]                   pend_rdata;

	spfa_ram #(.WIDTH(8), .DEPTH(spfa_pkg::POOL_DEPTH)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	spfa_ram #(.WIDTH(8), .DEPTH(spfa_pkg::MAX_STRING_BYTES)) u_pend (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_waddr),
		.wdata (in_char),
		.raddr (pend_raddr),
		.rdata (pend_rdata)
	);

	logic accept;
	assign accept = s_tvalid && s_tready;

	// Scan issue: the limit of the current block is the append point.
	logic [spfa_pkg::LIM_W-1:0] scan_limit;
	logic                       scan_issue;
	assign scan_limit = (sb_q[spfa_pkg::BLK_W-1:0] == cur_blk_q) ? cur_off_q : LIMIT_FULL;
	assign scan_issue = (state_q == spfa_pkg::ST_SCAN) && !sdone_q && (si_q < scan_limit);

	// Scan evaluate: a new block restarts the run tracking.
	logic                       first_s1;
	logic                       skip_eff;
	logic [spfa_pkg::LEN_W-1:0] run_eff;
	logic                       skip_n;
	logic [spfa_pkg::LEN_W-1:0] run_n;
	logic [spfa_pkg::OFF_W-1:0] start_n;
	logic                       found;

	assign first_s1 = (si_s1 == '0);
	assign skip_eff = first_s1 ? 1'b0 : skip_q;
	assign run_eff  = first_s1 ? '0 : run_q;

	always_comb begin
		skip_n  = skip_eff;
		run_n   = run_eff;
		start_n = start_q;
		found   = 1'b0;
		if (!skip_eff) begin
			if (pool_rdata == 8'd0) begin
				if (run_eff == '0) begin
					start_n = si_s1;
				end
				run_n = run_eff + 1'b1;
				found = sv_s1 && (run_n >= need_q);
			end else begin
				run_n  = '0;
				skip_n = 1'b1;
			end
		end else if (pool_rdata == 8'd0) begin
			// A stored string's terminator is passed over, not counted.
			skip_n = 1'b0;
			run_n  = '0;
		end
	end

	logic scan_miss;
	assign scan_miss = sdone_q && !sv_s1;

	// Placement when the scan finds no hole.
	logic [spfa_pkg::LIM_W:0] app_end;
	logic                     can_append;
	assign app_end    = {1'b0, cur_off_q} + (spfa_pkg::LIM_W+1)'(need_q);
	assign can_append = (blocks_q != '0) && (app_end <= (spfa_pkg::LIM_W+1)'(spfa_pkg::BLOCK_BYTES));

	// Free walk: next offset stays inside the block.
	logic [spfa_pkg::LIM_W-1:0] woff_next;
	logic                       free_more;
	assign woff_next = woff_q + 1'b1;
	assign free_more = (pool_rdata != 8'd0) && (woff_next < LIMIT_FULL);

	logic resp_go;
	assign resp_go = !out_valid_q || m_tready;

	logic key_bad;
	assign key_bad = (in_kind != spfa_pkg::KIND_ORD) ||
		({1'b0, in_blk} >= blocks_q);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			spfa_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_n = spfa_pkg::ST_IDLE;
				end
			end
			spfa_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_op)
						spfa_pkg::OP_ALLOC: begin
							if (in_char == 8'd0) begin
								if (pend_len_q == '0 || pend_len_q >= LEN_MAX) begin
									state_n = spfa_pkg::ST_RESP;
								end else begin
									state_n = spfa_pkg::ST_SCAN;
								end
							end
						end
						spfa_pkg::OP_FREE: begin
							if (in_kind == spfa_pkg::KIND_EMPTY || key_bad) begin
								state_n = spfa_pkg::ST_RESP;
							end else begin
								state_n = spfa_pkg::ST_FREE;
							end
						end
						spfa_pkg::OP_READ: begin
							if (in_kind == spfa_pkg::KIND_EMPTY || key_bad ||
								in_rd_off >= LIMIT_FULL) begin
								state_n = spfa_pkg::ST_RESP;
							end else begin
								state_n = spfa_pkg::ST_READ;
							end
						end
						default: state_n = spfa_pkg::ST_IDLE;
					endcase
				end
			end
			spfa_pkg::ST_READ: state_n = spfa_pkg::ST_RESP;
			spfa_pkg::ST_FREE: begin
				if (!free_more) begin
					state_n = spfa_pkg::ST_RESP;
				end
			end
			spfa_pkg::ST_SCAN: begin
				if (found) begin
					state_n = spfa_pkg::ST_STORE;
				end else if (scan_miss) begin
					state_n = spfa_pkg::ST_PLACE;
				end
			end
			spfa_pkg::ST_PLACE: begin
				if (can_append || blocks_q < spfa_pkg::BCNT_W'(spfa_pkg::BLOCK_COUNT)) begin
					state_n = spfa_pkg::ST_STORE;
				end else begin
					state_n = spfa_pkg::ST_RESP;
				end
			end
			spfa_pkg::ST_STORE: begin
				if (k_q == slen_q && !pv_s1) begin
					state_n = spfa_pkg::ST_RESP;
				end
			end
			spfa_pkg::ST_RESP: begin
				if (resp_go) begin
					state_n = spfa_pkg::ST_IDLE;
				end
			end
			default: state_n = spfa_pkg::ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer: handshake and memory ports.
	always_comb begin
		s_tready   = (state_q == spfa_pkg::ST_IDLE);
		pool_we    = 1'b0;
		pool_waddr = clr_q;
		pool_wdata = 8'd0;
		pool_raddr = in_key;
		pend_we    = 1'b0;
		pend_waddr = pend_len_q[spfa_pkg::PEND_AW-1:0];
		pend_raddr = k_q[spfa_pkg::PEND_AW-1:0];
		case (state_q)
			spfa_pkg::ST_CLEAR: begin
				pool_we = 1'b1;
			end
			spfa_pkg::ST_IDLE: begin
				if (in_op == spfa_pkg::OP_READ) begin
					pool_raddr = {in_blk, in_rd_off[spfa_pkg::OFF_W-1:0]};
				end
				pend_we = accept && (in_op == spfa_pkg::OP_ALLOC) && (in_char != 8'd0) &&
					(pend_len_q < LEN_MAX - 1'b1);
			end
			spfa_pkg::ST_FREE: begin
				pool_we    = (pool_rdata != 8'd0);
				pool_waddr = {wblk_q, woff_q[spfa_pkg::OFF_W-1:0]};
				pool_raddr = {wblk_q, woff_next[spfa_pkg::OFF_W-1:0]};
			end
			spfa_pkg::ST_SCAN: begin
				pool_raddr = {sb_q[spfa_pkg::BLK_W-1:0], si_q[spfa_pkg::OFF_W-1:0]};
			end
			spfa_pkg::ST_STORE: begin
				if (pv_s1) begin
					pool_we    = 1'b1;
					pool_waddr = pos_q + spfa_pkg::POOL_AW'(k_s1);
					pool_wdata = pend_rdata;
				end else if (k_q == slen_q) begin
					pool_we    = 1'b1;
					pool_waddr = pos_q + spfa_pkg::POOL_AW'(slen_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spfa_pkg::ST_CLEAR;
			clr_q       <= '0;
			blocks_q    <= '0;
			cur_blk_q   <= '0;
			cur_off_q   <= LIMIT_FULL;
			pend_len_q  <= '0;
			sv_s1       <= 1'b0;
			pv_s1       <= 1'b0;
			sdone_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			sv_s1   <= scan_issue;
			pv_s1   <= (state_q == spfa_pkg::ST_STORE) && (k_q < slen_q);

			if (state_q == spfa_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end

			if (accept && in_op == spfa_pkg::OP_ALLOC) begin
				if (in_char != 8'd0) begin
					if (pend_len_q < LEN_MAX) begin
						pend_len_q <= pend_len_q + 1'b1;
					end
				end else begin
					pend_len_q <= '0;
				end
			end

			if (state_q == spfa_pkg::ST_IDLE) begin
				sdone_q <= (blocks_q == '0);
			end else if (state_q == spfa_pkg::ST_SCAN && !sdone_q && !scan_issue) begin
				sdone_q <= ((sb_q + 1'b1) >= blocks_q);
			end

			if (state_q == spfa_pkg::ST_PLACE && !can_append &&
				blocks_q < spfa_pkg::BCNT_W'(spfa_pkg::BLOCK_COUNT)) begin
				cur_blk_q <= blocks_q[spfa_pkg::BLK_W-1:0];
				blocks_q  <= blocks_q + 1'b1;
				cur_off_q <= spfa_pkg::LIM_W'(need_q);
			end else if (state_q == spfa_pkg::ST_PLACE && can_append) begin
				cur_off_q <= app_end[spfa_pkg::LIM_W-1:0];
			end

			if (state_q == spfa_pkg::ST_RESP && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		sb_s1 <= sb_q[spfa_pkg::BLK_W-1:0];
		si_s1 <= si_q[spfa_pkg::OFF_W-1:0];
		k_s1  <= k_q;

		if (state_q == spfa_pkg::ST_RESP && resp_go) begin
			out_stat_q <= res_stat_q;
			out_key_q  <= res_key_q;
			out_byte_q <= res_byte_q;
		end

		case (state_q)
			spfa_pkg::ST_IDLE: begin
				res_key_q  <= '0;
				res_byte_q <= 8'd0;
				res_stat_q <= spfa_pkg::STAT_OK;
				wblk_q     <= in_blk;
				woff_q     <= {1'b0, in_key[spfa_pkg::OFF_W-1:0]};
				sb_q       <= '0;
				si_q       <= '0;
				k_q        <= '0;
				slen_q     <= pend_len_q;
				need_q     <= pend_len_q + 1'b1;
				if (in_op == spfa_pkg::OP_ALLOC) begin
					if (pend_len_q == '0) begin
						res_stat_q <= spfa_pkg::STAT_EMPTY;
					end else if (pend_len_q >= LEN_MAX) begin
						res_stat_q <= spfa_pkg::STAT_INVALID;
					end
				end else if (in_kind == spfa_pkg::KIND_EMPTY) begin
					res_stat_q <= spfa_pkg::STAT_EMPTY;
				end else if (key_bad ||
					(in_op == spfa_pkg::OP_READ && in_rd_off >= LIMIT_FULL)) begin
					res_stat_q <= spfa_pkg::STAT_INVALID;
				end
			end
			spfa_pkg::ST_READ: begin
				res_byte_q <= pool_rdata;
			end
			spfa_pkg::ST_FREE: begin
				woff_q <= woff_next;
			end
			spfa_pkg::ST_SCAN: begin
				if (sv_s1) begin
					skip_q  <= skip_n;
					run_q   <= run_n;
					start_q <= start_n;
				end
				if (found) begin
					pos_q     <= {sb_s1, start_n};
					res_key_q <= {sb_s1, start_n};
				end
				if (scan_issue) begin
					si_q <= si_q + 1'b1;
				end else if (!sdone_q) begin
					si_q <= '0;
					sb_q <= sb_q + 1'b1;
				end
			end
			spfa_pkg::ST_PLACE: begin
				if (can_append) begin
					pos_q     <= {cur_blk_q, cur_off_q[spfa_pkg::OFF_W-1:0]};
					res_key_q <= {cur_blk_q, cur_off_q[spfa_pkg::OFF_W-1:0]};
				end else if (blocks_q < spfa_pkg::BCNT_W'(spfa_pkg::BLOCK_COUNT)) begin
					pos_q     <= {blocks_q[spfa_pkg::BLK_W-1:0], {spfa_pkg::OFF_W{1'b0}}};
					res_key_q <= {blocks_q[spfa_pkg::BLK_W-1:0], {spfa_pkg::OFF_W{1'b0}}};
				end else begin
					res_stat_q <= spfa_pkg::STAT_INVALID;
				end
			end
			spfa_pkg::ST_STORE: begin
				if (k_q < slen_q) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_stat_q;
	assign m_tdata  = {2'b00, out_byte_q, out_key_q};

	// The pool is only written by the sweep, a free walk or a string copy.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spfa_pkg::ST_IDLE || state_q == spfa_pkg::ST_RESP) |-> !pool_we)
		else $error("pool written while no operation is running");

	a_blocks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		blocks_q <= spfa_pkg::BCNT_W'(spfa_pkg::BLOCK_COUNT))
		else $error("block count beyond the pool");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_off_q <= LIMIT_FULL)
		else $error("append point beyond the block end");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_we |-> (pend_len_q < LEN_MAX - 1'b1))
		else $error("pending character written beyond the buffer");

	a_store_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spfa_pkg::ST_STORE && $past(state_q) != spfa_pkg::ST_STORE) |->
		($past(state_q) == spfa_pkg::ST_SCAN || $past(state_q) == spfa_pkg::ST_PLACE))
		else $error("string copy started without a placement");

endmodule
